// ----- rtl/ordered_timer_queue_macros.svh -----
// Assertion macros for the ordered timer queue
`ifndef ORDERED_TIMER_QUEUE_MACROS_SVH
`define ORDERED_TIMER_QUEUE_MACROS_SVH
// property: under reset disable, antecedent implies consequent next cycle
`define OTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
// property: same-cycle implication
`define OTQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`endif

// ----- rtl/otq_pkg.sv -----
// ----------------------------------------------------------------------------
// otq_pkg
// Types and constants shared by the ordered timer queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package otq_pkg;
	localparam int TimeW = 48;
	localparam int IdW = 32;
	localparam int DefCapacity = 64;

	typedef enum logic [1:0] {
		REQ_ADD = 2'd0,
		REQ_DEL = 2'd1,
		REQ_CHECK = 2'd2,
		REQ_SLEEP = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_DONE = 3'd0,
		ST_FULL = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_NOT_DUE = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [TimeW-1:0] now_ms;
		logic [IdW-1:0] delay_ms;
		logic [IdW-1:0] key_id;
		logic [TimeW-1:0] key_expire;
	} req_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [IdW-1:0] out_id;
		logic [TimeW-1:0] out_expire;
		logic [TimeW-1:0] wait_ms;
	} rsp_item_t;
endpackage
`default_nettype wire

// ----- rtl/otq_if.sv -----
// ----------------------------------------------------------------------------
// otq_if
// Valid/ready channel carrying one packed item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface otq_if #(parameter type item_t = logic) ();
	logic valid;
	logic ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/ordered_timer_queue.sv -----
// Each request takes one scan of the slot RAM, one entry per cycle, then a
// write step and the output register. One request at a time: a stalled
// result holds off the next request.
// Reset clears the valid bits, the identifier counter and the live count;
// the slot RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// ordered_timer_queue
// Bounded timer table ordered by (expiry, identifier) with add, delete,
// check-expiry and sleep queries, scanned from a single-port RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ordered_timer_queue #(
	parameter int Capacity = otq_pkg::DefCapacity
) (
	input wire logic clk,
	input wire logic arst_n,
	otq_if.sink req,
	otq_if.source rsp
);
	import otq_pkg::*;

	localparam int AW = $clog2(Capacity);
	localparam int CW = $clog2(Capacity + 1);
	localparam int EW = TimeW + IdW;

	state_t state_q, state_d;
	req_item_t item_q;
	logic [TimeW-1:0] exp_q;
	logic [CW-1:0] idx_q;
	logic [Capacity-1:0] valid_q;
	logic [IdW-1:0] next_id_q;
	logic [CW-1:0] live_q;
	logic hit_q, free_found_q, rd_ok_s1;
	logic [AW-1:0] hit_idx_q, free_idx_q, rd_idx_s1;
	logic [EW-1:0] best_q;
	logic [EW-1:0] rdata;
	logic [EW-1:0] wdata;
	logic we;
	logic [AW-1:0] addr;
	rsp_item_t out_q;
	logic out_valid_q;

	// Entry word: expiry in the high bits so one compare orders (expiry, id)
	otq_ram #(.Width(EW), .Depth(Capacity)) u_slots (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	logic [TimeW:0] sum;
	assign sum = {1'b0, req.data.now_ms} + {{(TimeW-IdW+1){1'b0}}, req.data.delay_ms};

	logic scan_last;
	assign scan_last = (idx_q == CW'(Capacity));
	assign we = (state_q == S_WRITE) && (item_q.req_type == REQ_ADD) && !hit_q
		&& free_found_q;
	assign wdata = {exp_q, next_id_q};
	assign addr = (state_q == S_WRITE) ? free_idx_q : idx_q[AW-1:0];
	assign req.ready = (state_q == S_IDLE) && !out_valid_q;
	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (req.valid && req.ready) state_d = S_SCAN;
			S_SCAN: if (scan_last && !rd_ok_s1) state_d = S_WRITE;
			S_WRITE: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic [EW-1:0] key;
	assign key = (item_q.req_type == REQ_ADD) ? {exp_q, next_id_q}
		: {item_q.key_expire, item_q.key_id};

	logic [TimeW-1:0] best_exp;
	logic [IdW-1:0] best_id;
	assign best_exp = best_q[EW-1:IdW];
	assign best_id = best_q[IdW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			next_id_q <= '0;
			live_q <= '0;
			out_valid_q <= 1'b0;
			rd_ok_s1 <= 1'b0;
			hit_q <= 1'b0;
			free_found_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						item_q <= req.data;
						exp_q <= sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
						idx_q <= '0;
						hit_q <= 1'b0;
						free_found_q <= 1'b0;
						rd_ok_s1 <= 1'b0;
					end
				end
				S_SCAN: begin
					// read issued at idx_q, data returns in the following cycle
					rd_ok_s1 <= !scan_last;
					rd_idx_s1 <= idx_q[AW-1:0];
					if (!scan_last) idx_q <= idx_q + 1'b1;
					if (!scan_last && !valid_q[idx_q[AW-1:0]] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q <= idx_q[AW-1:0];
					end
					if (rd_ok_s1 && valid_q[rd_idx_s1]) begin
						if (rdata == key && !hit_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= rd_idx_s1;
						end
						if (!hit_q || rdata < best_q) begin
							if (item_q.req_type == REQ_CHECK
								|| item_q.req_type == REQ_SLEEP) begin
								if (!hit_q || rdata < best_q) begin
									best_q <= rdata;
									hit_idx_q <= rd_idx_s1;
									hit_q <= 1'b1;
								end
							end
						end
					end
				end
				S_WRITE: begin
					out_q <= '0;
					out_valid_q <= 1'b1;
					case (item_q.req_type)
						REQ_ADD: begin
							if (hit_q) begin
								next_id_q <= next_id_q + 1'b1;
								out_q.out_id <= next_id_q;
								out_q.out_expire <= exp_q;
							end else if (live_q >= CW'(Capacity) || !free_found_q) begin
								out_q.status <= ST_FULL;
							end else begin
								valid_q[free_idx_q] <= 1'b1;
								live_q <= live_q + 1'b1;
								next_id_q <= next_id_q + 1'b1;
								out_q.out_id <= next_id_q;
								out_q.out_expire <= exp_q;
							end
						end
						REQ_DEL: begin
							if (hit_q) begin
								valid_q[hit_idx_q] <= 1'b0;
								if (live_q != '0) live_q <= live_q - 1'b1;
							end else begin
								out_q.status <= ST_NOT_FOUND;
							end
						end
						REQ_CHECK: begin
							if (!hit_q) begin
								out_q.status <= ST_EMPTY;
							end else if (best_exp <= item_q.now_ms) begin
								out_q.out_id <= best_id;
								out_q.out_expire <= best_exp;
								valid_q[hit_idx_q] <= 1'b0;
								if (live_q != '0) live_q <= live_q - 1'b1;
							end else begin
								out_q.status <= ST_NOT_DUE;
							end
						end
						REQ_SLEEP: begin
							if (!hit_q) begin
								out_q.status <= ST_EMPTY;
							end else if (best_exp > item_q.now_ms) begin
								out_q.wait_ms <= best_exp - item_q.now_ms;
							end
						end
						default: out_q.status <= ST_DONE;
					endcase
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/otq_ram.sv -----
// ----------------------------------------------------------------------------
// otq_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module otq_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] addr,
	input wire logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ----- rtl/otq_checker.sv -----
// ----------------------------------------------------------------------------
// otq_checker
// Port-level checks on the timer queue handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_timer_queue_macros.svh"
module otq_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic [2:0] rsp_status
);
	import otq_pkg::*;

	// a request is only taken with no result pending
	`OTQ_ASSERT_NOW(a_no_take_pending, clk, arst_n, req_valid && req_ready, !rsp_valid, "request taken while result pending")
	// after a request is taken the block is busy next cycle
	`OTQ_ASSERT_NEXT(a_busy_after_take, clk, arst_n, req_valid && req_ready, !req_ready, "ready stayed high after take")
	// status stays within its codes
	`OTQ_ASSERT_NOW(a_status_code, clk, arst_n, rsp_valid, rsp_status <= 3'(ST_EMPTY), "bad status code")
	// a stalled result holds
	`OTQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
endmodule

bind ordered_timer_queue otq_checker u_otq_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_status(rsp.data.status)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered timer queue. It drives timer requests
// in bursts and tracks a local copy of the timer table to predict each
// result. Results are compared field by field, in order, while the response
// side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
	import otq_pkg::*;

	localparam int Slots = DefCapacity;
	localparam logic [TimeW-1:0] TimeMax = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	otq_if #(.item_t(req_item_t)) req_ch ();
	otq_if #(.item_t(rsp_item_t)) rsp_ch ();

	ordered_timer_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// local timer table
	logic [TimeW-1:0] tmr_exp [Slots];
	logic [IdW-1:0] tmr_id [Slots];
	bit tmr_live [Slots];
	logic [IdW-1:0] id_next;
	int live_num;

	rsp_item_t pending_rsps [$];
	int errors = 0;
	int rsp_seen = 0;
	int status_hits [5];
	int burst_left = 0;
	logic [TimeW-1:0] cur_now = '0;

	function automatic int find_key(logic [TimeW-1:0] e, logic [IdW-1:0] id);
		for (int i = 0; i < Slots; i++)
			if (tmr_live[i] && tmr_exp[i] == e && tmr_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic int earliest_timer();
		int best;
		best = -1;
		for (int i = 0; i < Slots; i++) begin
			if (!tmr_live[i])
				continue;
			if (best < 0 || tmr_exp[i] < tmr_exp[best] ||
					(tmr_exp[i] == tmr_exp[best] && tmr_id[i] < tmr_id[best]))
				best = i;
		end
		return best;
	endfunction

	function automatic rsp_item_t timer_outcome(req_item_t it);
		rsp_item_t r;
		logic [TimeW:0] sum;
		logic [TimeW-1:0] e;
		int i;
		r = '0;
		r.status = ST_DONE;
		case (req_t'(it.req_type))
			REQ_ADD: begin
				sum = {1'b0, it.now_ms} + {17'b0, it.delay_ms};
				e = sum[TimeW] ? TimeMax : sum[TimeW-1:0];
				if (find_key(e, id_next) >= 0) begin
					r.out_id = id_next;
					r.out_expire = e;
					id_next++;
				end else if (live_num >= Slots) begin
					r.status = ST_FULL;
				end else begin
					for (i = 0; i < Slots; i++)
						if (!tmr_live[i])
							break;
					tmr_live[i] = 1'b1;
					tmr_exp[i] = e;
					tmr_id[i] = id_next;
					live_num++;
					r.out_id = id_next;
					r.out_expire = e;
					id_next++;
				end
			end
			REQ_DEL: begin
				i = find_key(it.key_expire, it.key_id);
				if (i >= 0) begin
					tmr_live[i] = 1'b0;
					live_num--;
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			REQ_CHECK: begin
				i = earliest_timer();
				if (i < 0) begin
					r.status = ST_EMPTY;
				end else if (tmr_exp[i] <= it.now_ms) begin
					r.out_id = tmr_id[i];
					r.out_expire = tmr_exp[i];
					tmr_live[i] = 1'b0;
					live_num--;
				end else begin
					r.status = ST_NOT_DUE;
				end
			end
			default: begin
				i = earliest_timer();
				if (i < 0)
					r.status = ST_EMPTY;
				else if (tmr_exp[i] > it.now_ms)
					r.wait_ms = tmr_exp[i] - it.now_ms;
			end
		endcase
		return r;
	endfunction

	task automatic send_req(req_item_t it);
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.data = it;
		do @(posedge clk); while (!req_ch.ready);
		pending_rsps.push_back(timer_outcome(it));
		burst_left--;
		if (burst_left <= 0) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
			req_ch.data = '0;
			repeat ($urandom_range(0, 90)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
	endtask

	task automatic send_fields(req_t kind, logic [TimeW-1:0] now, logic [IdW-1:0] delay,
			logic [IdW-1:0] kid, logic [TimeW-1:0] kexp);
		req_item_t it;
		it.req_type = kind;
		it.now_ms = now;
		it.delay_ms = delay;
		it.key_id = kid;
		it.key_expire = kexp;
		send_req(it);
	endtask

	// receiver stall pattern: phases of always-ready, coin flips, periodic ready windows and long stalls
	int stall_cnt = 0;
	int stall_mode = 0;
	always @(negedge clk) begin
		stall_cnt++;
		if (stall_cnt % 400 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: rsp_ch.ready = 1'b1;
			1: rsp_ch.ready = 1'($urandom_range(0, 1));
			2: rsp_ch.ready = (stall_cnt % 7) < 2;
			default: rsp_ch.ready = ($urandom_range(0, 30) == 0);
		endcase
	end

	always @(posedge clk) begin
		rsp_item_t exp_r;
		rsp_item_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.data;
			rsp_seen++;
			if (pending_rsps.size() == 0) begin
				$display("%0t unexpected result %p", $time, got);
				errors++;
			end else begin
				exp_r = pending_rsps.pop_front();
				if (exp_r.status < 5)
					status_hits[exp_r.status]++;
				if (got.status !== exp_r.status) begin
					$display("%0t status exp %0d got %0d", $time, exp_r.status, got.status);
					errors++;
				end
				if (got.out_id !== exp_r.out_id) begin
					$display("%0t out_id exp %h got %h", $time, exp_r.out_id, got.out_id);
					errors++;
				end
				if (got.out_expire !== exp_r.out_expire) begin
					$display("%0t out_expire exp %h got %h", $time, exp_r.out_expire,
						got.out_expire);
					errors++;
				end
				if (got.wait_ms !== exp_r.wait_ms) begin
					$display("%0t wait_ms exp %h got %h", $time, exp_r.wait_ms, got.wait_ms);
					errors++;
				end
			end
		end
	end

	task automatic test_empty_table();
		send_fields(REQ_SLEEP, '0, '0, '0, '0);
		send_fields(REQ_CHECK, TimeMax, '1, '1, '1);
		send_fields(REQ_DEL, '0, '0, '0, '0);
		send_fields(REQ_DEL, TimeMax, '1, '1, TimeMax);
	endtask

	task automatic test_add_and_fire();
		send_fields(REQ_ADD, '0, '0, '0, '0);
		send_fields(REQ_ADD, TimeMax, '1, '1, '1);      // expiry saturates
		send_fields(REQ_ADD, TimeMax - 5, 32'd5, '0, '0); // lands exactly on max
		send_fields(REQ_ADD, 48'd100, 32'd50, '0, '0);
		send_fields(REQ_ADD, 48'd100, 32'd50, '0, '0);  // same expiry, id breaks tie
		send_fields(REQ_SLEEP, '0, '0, '0, '0);          // earliest already due
		send_fields(REQ_CHECK, '0, '0, '0, '0);          // fires the zero timer
		send_fields(REQ_SLEEP, 48'd20, '0, '0, '0);
		send_fields(REQ_CHECK, 48'd149, '0, '0, '0);     // not yet due
		send_fields(REQ_CHECK, 48'd150, '0, '0, '0);
		send_fields(REQ_DEL, '0, '0, 32'd4, 48'd150);
		send_fields(REQ_DEL, '0, '0, 32'd4, 48'd150);    // gone now
		send_fields(REQ_DEL, '0, '0, 32'd1, TimeMax);
		send_fields(REQ_SLEEP, TimeMax, '0, '0, '0);
		send_fields(REQ_CHECK, TimeMax, '0, '0, '0);
		send_fields(REQ_SLEEP, '0, '0, '0, '0);
	endtask

	task automatic test_full_table();
		for (int n = 0; n <= Slots; n++)
			send_fields(REQ_ADD, 48'd1000, $urandom_range(0, 3000), '0, '0);
		send_fields(REQ_ADD, TimeMax, '1, '0, '0);
		for (int n = 0; n < Slots + 1; n++)
			send_fields(REQ_CHECK, TimeMax, '0, '0, '0);
	endtask

	task automatic test_random_mix(int count);
		req_item_t it;
		int pick;
		int slot;
		for (int n = 0; n < count; n++) begin
			cur_now += 48'($urandom_range(0, 25));
			it.now_ms = cur_now;
			it.delay_ms = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 300);
			it.key_id = $urandom();
			it.key_expire = 48'({$urandom(), $urandom()});
			if ($urandom_range(0, 19) == 0)
				it.now_ms = 48'({$urandom(), $urandom()});
			pick = $urandom_range(0, 99);
			if (pick < 42 - live_num / 3) begin
				it.req_type = REQ_ADD;
			end else if (pick < 60) begin
				it.req_type = REQ_DEL;
				if (live_num > 0 && $urandom_range(0, 4) != 0) begin
					do slot = $urandom_range(0, Slots - 1); while (!tmr_live[slot]);
					it.key_id = tmr_id[slot];
					it.key_expire = tmr_exp[slot];
				end
			end else if (pick < 85) begin
				it.req_type = REQ_CHECK;
			end else begin
				it.req_type = REQ_SLEEP;
			end
			send_req(it);
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < Slots; i++)
			tmr_live[i] = 1'b0;
		id_next = '0;
		live_num = 0;
		cur_now = {16'b0, $urandom()};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_add_and_fire();
		test_full_table();
		test_random_mix(800);

		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);

		$display("results checked: %0d (done %0d, full %0d, miss %0d, not due %0d, empty %0d)",
			rsp_seen, status_hits[0], status_hits[1], status_hits[2], status_hits[3],
			status_hits[4]);
		if (errors == 0 && pending_rsps.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#40ms;
		$display("FAILURE");
		$finish;
	end
endmodule
